@@ hdl/dtmu_pkg.sv @@
// Shared types, codes and control word field positions for the debug trigger match unit.
package dtmu_pkg;

  localparam int DTMU_SLOTS_DEF = 8;
  localparam int WORD_W         = 64;
  localparam int HALF_W         = 32;
  localparam int MASK_MAX_W     = 6;
  localparam logic [MASK_MAX_W-1:0] MASK_MAX_RST = 6'd63;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FETCH = 2'd2,
    REQ_COUNT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // trigger types
  localparam logic [3:0] TYPE_ADDR   = 4'd2;
  localparam logic [3:0] TYPE_ICOUNT = 4'd3;

  // address match modes
  localparam logic [3:0] MATCH_EQ     = 4'd0;
  localparam logic [3:0] MATCH_MASK   = 4'd1;
  localparam logic [3:0] MATCH_GE     = 4'd2;
  localparam logic [3:0] MATCH_LT     = 4'd3;
  localparam logic [3:0] MATCH_LO_MSK = 4'd4;
  localparam logic [3:0] MATCH_HI_MSK = 4'd5;

  // action codes in the control word and as reported
  localparam logic [3:0] ACT_SWI   = 4'd0;
  localparam logic [3:0] ACT_HALT  = 4'd1;
  localparam logic [1:0] FIRE_SWI   = 2'd0;
  localparam logic [1:0] FIRE_HALT  = 2'd1;
  localparam logic [1:0] FIRE_OTHER = 2'd2;

  // address match control word fields
  localparam int TYPE_LO   = 60;
  localparam int AM_HIT    = 20;
  localparam int AM_ACT_LO = 12;
  localparam int AM_MCH_LO = 7;
  localparam int AM_M      = 6;
  localparam int AM_S      = 4;
  localparam int AM_U      = 3;
  localparam int AM_EXEC   = 2;

  // instruction count control word fields
  localparam int IC_HIT    = 24;
  localparam int IC_CNT_LO = 10;
  localparam int IC_CNT_W  = 14;
  localparam int IC_M      = 9;
  localparam int IC_S      = 7;
  localparam int IC_U      = 6;

  typedef struct packed {
    logic              wr_en;
    logic [WORD_W-1:0] ctl_new;
    logic              addr_hit;
    logic [3:0]        action;
    logic              cnt_one;
  } slot_res_t;

endpackage

@@ hdl/dtmu_if.sv @@
// Valid/ready channel interfaces for request and result words.
interface dtmu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  slot_index;
  logic        word_select;
  logic [63:0] write_value;
  logic [63:0] fetch_address;

  modport source (output valid, req_type, slot_index, word_select, write_value,
                  fetch_address, input ready);
  modport sink (input valid, req_type, slot_index, word_select, write_value,
                fetch_address, output ready);
endinterface

interface dtmu_out_if;
  logic        valid;
  logic        ready;
  logic        address_fired;
  logic [1:0]  fire_action;
  logic        count_fired;
  logic [63:0] read_value;

  modport source (output valid, address_fired, fire_action, count_fired, read_value,
                  input ready);
  modport sink (input valid, address_fired, fire_action, count_fired, read_value,
                output ready);
endinterface

@@ hdl/dtmu_slot_eval.sv @@
// Evaluates one trigger slot for a fetch check or an instruction count step.
module dtmu_slot_eval import dtmu_pkg::*; (
  input  req_t                  req,
  input  logic [WORD_W-1:0]     ctl,
  input  logic [WORD_W-1:0]     cmp,
  input  logic [WORD_W-1:0]     pc,
  input  logic [MASK_MAX_W-1:0] mask_max,
  output slot_res_t             res
);

  always_comb begin
    logic [WORD_W-1:0]   below;
    logic [WORD_W-1:0]   lim;
    logic [WORD_W-1:0]   amask;
    logic                match;
    logic [WORD_W-1:0]   c;
    logic [IC_CNT_W-1:0] cnt;

    // ones below the lowest set bit of cmp, capped at mask_max bits
    below = ~cmp & (cmp - 64'd1);
    lim   = (64'd1 << mask_max) - 64'd1;
    amask = ~(below & lim);

    case (ctl[AM_MCH_LO +: 4])
      MATCH_EQ:     match = (pc == cmp);
      MATCH_MASK:   match = ((pc & amask) == (cmp & amask));
      MATCH_GE:     match = (pc >= cmp);
      MATCH_LT:     match = (pc < cmp);
      MATCH_LO_MSK: match = ((pc[HALF_W-1:0] & cmp[WORD_W-1:HALF_W]) == cmp[HALF_W-1:0]);
      MATCH_HI_MSK: match = ((pc[WORD_W-1:HALF_W] & cmp[WORD_W-1:HALF_W])
                             == cmp[HALF_W-1:0]);
      default:      match = 1'b0;
    endcase

    c   = ctl;
    cnt = ctl[IC_CNT_LO +: IC_CNT_W];
    res = '0;

    if (req == REQ_FETCH) begin
      if (ctl[TYPE_LO +: 4] == TYPE_ADDR && (ctl[AM_M] | ctl[AM_S] | ctl[AM_U])
          && ctl[AM_EXEC]) begin
        c[AM_HIT]    = ctl[AM_HIT] | match;
        res.wr_en    = 1'b1;
        res.ctl_new  = c;
        res.addr_hit = c[AM_HIT];
        res.action   = c[AM_ACT_LO +: 4];
      end
    end else if (req == REQ_COUNT) begin
      if (ctl[TYPE_LO +: 4] == TYPE_ICOUNT) begin
        res.cnt_one = (cnt == IC_CNT_W'(1));
        if (cnt > IC_CNT_W'(1) && (ctl[IC_M] | ctl[IC_S] | ctl[IC_U])) begin
          c[IC_CNT_LO +: IC_CNT_W] = cnt - IC_CNT_W'(1);
        end
        c[IC_HIT]   = 1'b1;
        res.wr_en   = 1'b1;
        res.ctl_new = c;
      end
    end
  end

endmodule

@@ hdl/debug_trigger_match_unit_top.sv @@
// Top level of the debug trigger match unit: trigger table memories and slot sequencer.
//
// Request words arrive on in_chan: write or read one trigger word, check a fetch
// address against all execute address triggers, or step the instruction counters.
// Every request word yields exactly one result word on out_chan.
// A read or write visits only its addressed slot. A fetch check or count step
// walks all TRIGGER_SLOTS slots in order, one slot per cycle, set by the single
// read/modify/write port of the control word memory, and its result word is
// loaded when the last slot is done.
// One request is in flight at a time; in_chan.ready is high when the sequencer is
// idle, which is also while a finished result waits in the output register.
// If the receiver stalls and the output register is still full when the next
// result completes, the sequencer holds that result and stops accepting requests.
// cfg_wr_en writes mask_max_bits; write it only while no request is in flight.
// Synchronous reset clears the table (per-entry valid bits make every word read as
// zero until written), sets mask_max_bits to 63 and empties the output register.
module debug_trigger_match_unit_top import dtmu_pkg::*; #(
  parameter int TRIGGER_SLOTS = DTMU_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dtmu_in_if.sink               in_chan,
  dtmu_out_if.source            out_chan,
  input  logic                  cfg_wr_en,
  input  logic [MASK_MAX_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (TRIGGER_SLOTS > 1) ? $clog2(TRIGGER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRIGGER_SLOTS - 1);

  state_t                state_r, state_nxt;
  logic [MASK_MAX_W-1:0] mask_max_r;
  req_t                  req_r;
  logic [2:0]            slot_r;
  logic                  sel_r;
  logic [WORD_W-1:0]     wval_r;
  logic [WORD_W-1:0]     pc_r;
  logic [IDX_W-1:0]      idx_r;

  logic                  afired_r, afired_nxt;
  logic [3:0]            action_r, action_nxt;
  logic                  cfired_r, cfired_nxt;
  logic [WORD_W-1:0]     rval_r, rval_nxt;

  logic                  out_valid_r;
  logic                  out_afired_r;
  logic [1:0]            out_action_r;
  logic                  out_cfired_r;
  logic [WORD_W-1:0]     out_rval_r;

  logic [WORD_W-1:0]        ctl_mem [TRIGGER_SLOTS];
  logic [WORD_W-1:0]        cmp_mem [TRIGGER_SLOTS];
  logic [TRIGGER_SLOTS-1:0] ctl_vld_r;
  logic [TRIGGER_SLOTS-1:0] cmp_vld_r;
  logic [WORD_W-1:0]        rd_ctl_r;
  logic [WORD_W-1:0]        rd_cmp_r;
  logic                     rd_ctl_vld_r;
  logic                     rd_cmp_vld_r;

  logic              accept;
  req_t              in_req;
  logic              in_scan;
  logic              scan_r;
  logic              slot_ok_r;
  logic              last;
  logic              out_free;
  logic              out_load;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] ctl_q;
  logic [WORD_W-1:0] cmp_q;
  logic              ctl_we;
  logic              cmp_we;
  logic [WORD_W-1:0] ctl_wdata;
  slot_res_t         res;
  logic              fin_afired;
  logic [3:0]        fin_action;
  logic              fin_cfired;
  logic [WORD_W-1:0] fin_rval;
  logic [1:0]        fire_code;

  assign in_req    = req_t'(in_chan.req_type);
  assign accept    = in_chan.valid && in_chan.ready;
  assign in_scan   = (in_req == REQ_FETCH) || (in_req == REQ_COUNT);
  assign scan_r    = (req_r == REQ_FETCH) || (req_r == REQ_COUNT);
  assign slot_ok_r = (32'(slot_r) < TRIGGER_SLOTS);
  assign last      = !scan_r || (idx_r == LAST_IDX);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign ctl_q     = rd_ctl_vld_r ? rd_ctl_r : '0;
  assign cmp_q     = rd_cmp_vld_r ? rd_cmp_r : '0;

  dtmu_slot_eval u_eval (
    .req      (req_r),
    .ctl      (ctl_q),
    .cmp      (cmp_q),
    .pc       (pc_r),
    .mask_max (mask_max_r),
    .res      (res)
  );

  // read port and write-back control
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx_r + IDX_W'(1);
    ctl_we    = 1'b0;
    cmp_we    = 1'b0;
    ctl_wdata = scan_r ? res.ctl_new : wval_r;
    if (state_r == ST_IDLE) begin
      rd_en   = accept;
      rd_addr = in_scan ? '0 : IDX_W'(in_chan.slot_index);
    end else if (state_r == ST_RUN) begin
      rd_en  = scan_r && !last;
      ctl_we = scan_r ? res.wr_en : (req_r == REQ_WRITE && slot_ok_r && !sel_r);
      cmp_we = (req_r == REQ_WRITE) && slot_ok_r && sel_r;
    end
  end

  always_comb begin
    afired_nxt = afired_r | res.addr_hit;
    action_nxt = res.addr_hit ? res.action : action_r;
    cfired_nxt = cfired_r | res.cnt_one;
    rval_nxt   = (req_r == REQ_READ && slot_ok_r) ? (sel_r ? cmp_q : ctl_q) : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN: begin
        if (last) state_nxt = out_free ? ST_IDLE : ST_DONE;
      end
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_chan.ready = 1'b0;
    out_load      = 1'b0;
    fin_afired    = afired_r;
    fin_action    = action_r;
    fin_cfired    = cfired_r;
    fin_rval      = rval_r;
    case (state_r)
      ST_IDLE: in_chan.ready = 1'b1;
      ST_RUN: begin
        out_load   = last && out_free;
        fin_afired = afired_nxt;
        fin_action = action_nxt;
        fin_cfired = cfired_nxt;
        fin_rval   = rval_nxt;
      end
      ST_DONE: out_load = out_free;
      default: out_load = 1'b0;
    endcase
    if (!fin_afired) begin
      fire_code = FIRE_SWI;
    end else if (fin_action == ACT_SWI) begin
      fire_code = FIRE_SWI;
    end else if (fin_action == ACT_HALT) begin
      fire_code = FIRE_HALT;
    end else begin
      fire_code = FIRE_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mask_max_r   <= MASK_MAX_RST;
      out_valid_r  <= 1'b0;
      ctl_vld_r    <= '0;
      cmp_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) mask_max_r <= cfg_wr_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl_we) ctl_vld_r[idx_r] <= 1'b1;
      if (cmp_we) cmp_vld_r[idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req;
      slot_r   <= in_chan.slot_index;
      sel_r    <= in_chan.word_select;
      wval_r   <= in_chan.write_value;
      pc_r     <= in_chan.fetch_address;
      afired_r <= 1'b0;
      action_r <= '0;
      cfired_r <= 1'b0;
      rval_r   <= '0;
    end else if (state_r == ST_RUN) begin
      afired_r <= afired_nxt;
      action_r <= action_nxt;
      cfired_r <= cfired_nxt;
      rval_r   <= rval_nxt;
    end
    if (rd_en) idx_r <= rd_addr;
    if (out_load) begin
      out_afired_r <= fin_afired;
      out_action_r <= fire_code;
      out_cfired_r <= fin_cfired;
      out_rval_r   <= fin_rval;
    end
  end

  // trigger table
  always_ff @(posedge clk) begin
    if (ctl_we) ctl_mem[idx_r] <= ctl_wdata;
    if (cmp_we) cmp_mem[idx_r] <= wval_r;
    if (rd_en) begin
      rd_ctl_r     <= ctl_mem[rd_addr];
      rd_cmp_r     <= cmp_mem[rd_addr];
      rd_ctl_vld_r <= ctl_vld_r[rd_addr];
      rd_cmp_vld_r <= cmp_vld_r[rd_addr];
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.address_fired = out_afired_r;
  assign out_chan.fire_action   = out_action_r;
  assign out_chan.count_fired   = out_cfired_r;
  assign out_chan.read_value    = out_rval_r;

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && scan_r) |-> (idx_r <= LAST_IDX))
    else $error("slot scan index past last slot");

  a_done_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> out_valid_r)
    else $error("result held back while output register is empty");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN || $past(state_r) == ST_DONE))
    else $error("result word appeared without a finished request");

endmodule

@@ tb/tb_debug_trigger_match_unit_top.sv @@
// Testbench for the trigger table: directed word table, then random words checked by a predictor.
`timescale 1ns / 100ps

module tb_debug_trigger_match_unit_top import dtmu_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 170;

  typedef struct packed {
    req_t        req;
    logic [2:0]  slot;
    logic        sel;
    logic [63:0] wval;
    logic [63:0] pc;
  } trig_req_t;

  typedef struct packed {
    logic        address_fired;
    logic [1:0]  fire_action;
    logic        count_fired;
    logic [63:0] read_value;
  } trig_result_t;

  typedef struct {
    trig_req_t    rq;
    logic         typed;
    trig_result_t want;
  } table_row_t;

  localparam trig_result_t NO_FIRE = '0;
  localparam trig_result_t HALT_FIRE = '{address_fired: 1'b1, fire_action: FIRE_HALT,
                                         count_fired: 1'b0, read_value: 64'd0};

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [MASK_MAX_W-1:0] cfg_wr_data;

  dtmu_in_if  in_if ();
  dtmu_out_if out_if ();

  debug_trigger_match_unit_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [63:0]           ctl_mirror [DTMU_SLOTS_DEF];
  logic [63:0]           cmp_mirror [DTMU_SLOTS_DEF];
  logic [MASK_MAX_W-1:0] mask_max_mirror;

  trig_result_t pending_trig_results [$];
  table_row_t   dir_tab [$];
  trig_result_t got_word;
  trig_result_t want_word;
  int           mismatches;
  int           quiet_cycles;
  int           stall_left;
  bit           idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic addr_hit(logic [63:0] pc, logic [63:0] cmp, logic [3:0] mode);
    logic [63:0] m;
    int n;
    case (mode)
      MATCH_EQ: return pc == cmp;
      MATCH_MASK: begin
        n = 0;
        while (n < mask_max_mirror && !cmp[n]) n++;
        m = {64{1'b1}} << n;
        return (pc & m) == (cmp & m);
      end
      MATCH_GE: return pc >= cmp;
      MATCH_LT: return pc < cmp;
      MATCH_LO_MSK: return (pc[31:0] & cmp[63:32]) == cmp[31:0];
      MATCH_HI_MSK: return (pc[63:32] & cmp[63:32]) == cmp[31:0];
      default: return 1'b0;
    endcase
  endfunction

  function automatic trig_result_t predict_trigger_table(trig_req_t r);
    trig_result_t res;
    logic [63:0] c;
    logic [13:0] cnt;
    logic [3:0]  act;
    int i;
    res = '0;
    act = '0;
    case (r.req)
      REQ_WRITE: begin
        if (r.sel) cmp_mirror[r.slot] = r.wval;
        else ctl_mirror[r.slot] = r.wval;
      end
      REQ_READ: res.read_value = r.sel ? cmp_mirror[r.slot] : ctl_mirror[r.slot];
      REQ_FETCH: begin
        for (i = 0; i < DTMU_SLOTS_DEF; i++) begin
          c = ctl_mirror[i];
          if (c[TYPE_LO +: 4] == TYPE_ADDR && (c[AM_M] | c[AM_S] | c[AM_U])
              && c[AM_EXEC]) begin
            if (addr_hit(r.pc, cmp_mirror[i], c[AM_MCH_LO +: 4])) c[AM_HIT] = 1'b1;
            ctl_mirror[i] = c;
            if (c[AM_HIT]) begin
              res.address_fired = 1'b1;
              act = c[AM_ACT_LO +: 4];
            end
          end
        end
        if (res.address_fired)
          res.fire_action = (act == ACT_SWI) ? FIRE_SWI :
                            (act == ACT_HALT) ? FIRE_HALT : FIRE_OTHER;
      end
      default: begin
        for (i = 0; i < DTMU_SLOTS_DEF; i++) begin
          c = ctl_mirror[i];
          if (c[TYPE_LO +: 4] == TYPE_ICOUNT) begin
            cnt = c[IC_CNT_LO +: IC_CNT_W];
            if (cnt == 14'd1) res.count_fired = 1'b1;
            if (cnt > 14'd1 && (c[IC_M] | c[IC_S] | c[IC_U]))
              c[IC_CNT_LO +: IC_CNT_W] = cnt - 14'd1;
            c[IC_HIT] = 1'b1;
            ctl_mirror[i] = c;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [63:0] addr_ctl(logic [3:0] mode, logic [3:0] act, logic [2:0] priv,
                                           logic exec);
    logic [63:0] w;
    w = '0;
    w[TYPE_LO +: 4]   = TYPE_ADDR;
    w[AM_MCH_LO +: 4] = mode;
    w[AM_ACT_LO +: 4] = act;
    w[AM_M]           = priv[2];
    w[AM_S]           = priv[1];
    w[AM_U]           = priv[0];
    w[AM_EXEC]        = exec;
    return w;
  endfunction

  function automatic logic [63:0] icount_ctl(logic [13:0] cnt, logic [2:0] priv);
    logic [63:0] w;
    w = '0;
    w[TYPE_LO +: 4]            = TYPE_ICOUNT;
    w[IC_CNT_LO +: IC_CNT_W]   = cnt;
    w[IC_M]                    = priv[2];
    w[IC_S]                    = priv[1];
    w[IC_U]                    = priv[0];
    return w;
  endfunction

  // mostly well-formed trigger words so that fetch checks and count steps hit often
  function automatic trig_req_t rand_req();
    trig_req_t r;
    logic [63:0] c;
    logic [31:0] hm;
    int pick;
    int k;
    r.req  = REQ_READ;
    r.slot = 3'($urandom_range(0, 7));
    r.sel  = 1'($urandom_range(0, 1));
    r.wval = rand64();
    r.pc   = rand64();
    pick   = $urandom_range(0, 99);
    if (pick < 30) begin
      r.req = REQ_WRITE;
      c = rand64();
      if (r.sel) begin
        case ($urandom_range(0, 4))
          0: c = rand64() << $urandom_range(0, 63);
          1: begin
            hm = $urandom;
            c = {hm, hm & 32'($urandom)};
          end
          2: begin
            k = $urandom_range(0, 2);
            c = (k == 0) ? 64'd0 : (k == 1) ? {64{1'b1}} : {1'b1, 63'd0};
          end
          default: c = rand64();
        endcase
      end else begin
        k = $urandom_range(0, 9);
        if (k < 6) begin
          c[TYPE_LO +: 4]   = TYPE_ADDR;
          c[AM_MCH_LO +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(6, 15))
                                                          : 4'($urandom_range(0, 5));
          c[AM_ACT_LO +: 4] = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(2, 15))
                                                          : 4'($urandom_range(0, 1));
          c[AM_HIT]         = ($urandom_range(0, 7) == 0);
          c[AM_EXEC]        = ($urandom_range(0, 7) != 0);
        end else if (k < 9) begin
          c[TYPE_LO +: 4]          = TYPE_ICOUNT;
          c[IC_CNT_LO +: IC_CNT_W] = ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                                 : 14'($urandom_range(0, 4));
        end
      end
      r.wval = c;
    end else if (pick < 42) begin
      r.req = REQ_READ;
    end else if (pick < 75) begin
      r.req = REQ_FETCH;
      c = cmp_mirror[$urandom_range(0, DTMU_SLOTS_DEF - 1)];
      case ($urandom_range(0, 7))
        0, 1: r.pc = c;
        2: r.pc = c + 64'd1 - 64'($urandom_range(0, 2));
        3: r.pc = c ^ (rand64() & ((64'd1 << $urandom_range(0, 63)) - 64'd1));
        4: r.pc = {c[31:0] | (32'($urandom) & ~c[63:32]),
                   c[31:0] | (32'($urandom) & ~c[63:32])};
        5: r.pc = $urandom_range(0, 1) ? {64{1'b1}} : 64'd0;
        default: r.pc = rand64();
      endcase
    end else begin
      r.req = REQ_COUNT;
    end
    return r;
  endfunction

  task automatic add_row(req_t rq, logic [2:0] slot, logic sel, logic [63:0] wval,
                         logic [63:0] pc, logic typed, trig_result_t want);
    table_row_t row;
    row.rq    = '{req: rq, slot: slot, sel: sel, wval: wval, pc: pc};
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endtask

  task automatic send_req(trig_req_t r, logic typed, trig_result_t want);
    trig_result_t p;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.req_type      = r.req;
    in_if.slot_index    = r.slot;
    in_if.word_select   = r.sel;
    in_if.write_value   = r.wval;
    in_if.fetch_address = r.pc;
    do @(posedge clk); while (!in_if.ready);
    p = predict_trigger_table(r);
    pending_trig_results.push_back(typed ? want : p);
    @(negedge clk);
  endtask

  task automatic write_mask_max(logic [MASK_MAX_W-1:0] v);
    while (pending_trig_results.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mask_max_mirror = v;
  endtask

  task automatic report_word(string what, trig_result_t w, trig_result_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp fired=%0d act=%0d cnt=%0d rd=%h, got fired=%0d act=%0d cnt=%0d rd=%h",
               $realtime, what, w.address_fired, w.fire_action, w.count_fired, w.read_value,
               g.address_fired, g.fire_action, g.count_fired, g.read_value);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready = 1'b0;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_word.address_fired = out_if.address_fired;
      got_word.fire_action   = out_if.fire_action;
      got_word.count_fired   = out_if.count_fired;
      got_word.read_value    = out_if.read_value;
      if (pending_trig_results.size() == 0) begin
        report_word("unexpected word", NO_FIRE, got_word);
      end else begin
        want_word = pending_trig_results.pop_front();
        if (got_word.address_fired !== want_word.address_fired ||
            got_word.fire_action !== want_word.fire_action ||
            got_word.count_fired !== want_word.count_fired ||
            got_word.read_value !== want_word.read_value)
          report_word("word mismatch", want_word, got_word);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [MASK_MAX_W-1:0] setting;
    int ph;
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.req_type      = '0;
    in_if.slot_index    = '0;
    in_if.word_select   = 1'b0;
    in_if.write_value   = '0;
    in_if.fetch_address = '0;
    out_if.ready        = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    idle_on             = 1'b1;
    mismatches          = 0;
    quiet_cycles        = 0;
    stall_left          = 0;
    foreach (ctl_mirror[i]) begin
      ctl_mirror[i] = '0;
      cmp_mirror[i] = '0;
    end
    mask_max_mirror = MASK_MAX_RST;

    add_row(REQ_READ,  3'd0, 1'b0, 64'd0, 64'd0, 1'b1, NO_FIRE);
    add_row(REQ_READ,  3'd7, 1'b1, 64'd0, 64'd0, 1'b1, NO_FIRE);
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, {64{1'b1}}, 1'b1, NO_FIRE);
    add_row(REQ_COUNT, 3'd0, 1'b0, 64'd0, 64'd0, 1'b1, NO_FIRE);
    add_row(REQ_WRITE, 3'd0, 1'b1, {64{1'b1}}, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd0, 1'b0, addr_ctl(MATCH_EQ, ACT_HALT, 3'b100, 1'b1), 64'd0, 1'b0,
            NO_FIRE);
    add_row(REQ_READ,  3'd0, 1'b0, 64'd0, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, {64{1'b1}}, 1'b1, HALT_FIRE);
    // hit stays set
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, 64'd0, 1'b1, HALT_FIRE);
    add_row(REQ_WRITE, 3'd0, 1'b0, addr_ctl(MATCH_EQ, ACT_HALT, 3'b100, 1'b0), 64'd0, 1'b0,
            NO_FIRE);
    add_row(REQ_WRITE, 3'd1, 1'b1, 64'h1000, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd1, 1'b0, addr_ctl(MATCH_MASK, 4'd7, 3'b001, 1'b1), 64'd0, 1'b0,
            NO_FIRE);
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, 64'h1fff, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd2, 1'b1, {1'b1, 63'd0}, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd2, 1'b0, addr_ctl(MATCH_GE, ACT_SWI, 3'b010, 1'b1), 64'd0, 1'b0,
            NO_FIRE);
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, {1'b1, 63'd0}, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd3, 1'b1, 64'hffff_0000_1234_0000, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd3, 1'b0, addr_ctl(MATCH_LO_MSK, ACT_HALT, 3'b111, 1'b1), 64'd0, 1'b0,
            NO_FIRE);
    add_row(REQ_FETCH, 3'd0, 1'b0, 64'd0, 64'h0000_0000_1234_abcd, 1'b0, NO_FIRE);
    add_row(REQ_WRITE, 3'd4, 1'b0, icount_ctl(14'd2, 3'b100), 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_COUNT, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_COUNT, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0, NO_FIRE);
    // no privilege bits: count never moves
    add_row(REQ_WRITE, 3'd5, 1'b0, icount_ctl(14'h3fff, 3'b000), 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_COUNT, 3'd0, 1'b0, 64'd0, 64'd0, 1'b0, NO_FIRE);
    add_row(REQ_READ,  3'd5, 1'b0, 64'd0, 64'd0, 1'b0, NO_FIRE);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
    in_if.valid = 1'b0;

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: setting = '0;
        1: setting = MASK_MAX_W'($urandom_range(1, 62));
        2: setting = '1;
        3: setting = MASK_MAX_W'($urandom_range(1, 8));
        default: setting = MASK_MAX_W'($urandom_range(0, 63));
      endcase
      write_mask_max(setting);
      idle_on = (ph != 4);
      repeat (PHASE_WORDS) send_req(rand_req(), 1'b0, NO_FIRE);
      in_if.valid = 1'b0;
    end

    while (pending_trig_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_trig_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
